// ----- sv/humsc_pkg.sv -----
// humsc_pkg: shared types and constants of the humidity compensation core
// no dependencies; imported by every module of the block

package humsc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TEMP_CAL_1       = 3'd0;
  localparam logic [2:0] REG_TEMP_CAL_2       = 3'd1;
  localparam logic [2:0] REG_TEMP_CAL_3       = 3'd2;
  localparam logic [2:0] REG_HUM_CAL_1        = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_2        = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_3        = 3'd5;
  localparam logic [2:0] REG_HUM_CAL_45_BYTES = 3'd6;
  localparam logic [2:0] REG_HUM_CAL_6        = 3'd7;

  localparam int unsigned CFG_DATA_W = 24;

  // compensation constants
  localparam logic [31:0] TFINE_OFS = 32'd76800;
  localparam logic [31:0] ROUND_A   = 32'd16384;
  localparam logic [31:0] C_OFS     = 32'd32768;
  localparam logic [31:0] B_OFS     = 32'd2097152;
  localparam logic [31:0] ROUND_B   = 32'd8192;
  localparam logic [31:0] HUM_MAX   = 32'd419430400;

  typedef struct packed {
    logic        [15:0] temp_cal_1;
    logic signed [15:0] temp_cal_2;
    logic signed [15:0] temp_cal_3;
    logic        [7:0]  hum_cal_1;
    logic signed [15:0] hum_cal_2;
    logic        [7:0]  hum_cal_3;
    logic        [23:0] hum_cal_45_bytes;
    logic signed [7:0]  hum_cal_6;
  } humsc_cal_t;

  // payload handed from the temperature pipeline to the humidity pipeline
  typedef struct packed {
    logic [31:0] tfine;
    logic [15:0] adc_h;
  } humsc_temp_t;

endpackage

// ----- sv/humsc_ifs.sv -----
// humsc_ifs: valid/ready channel interfaces for samples and results
// depends on nothing but the port widths of the block

interface humsc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [15:0] raw_humidity;

  modport source (output valid, output raw_temperature, output raw_humidity, input ready);
  modport sink (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface humsc_result_if;
  logic               valid;
  logic               ready;
  logic        [16:0] humidity_q10;
  logic signed [31:0] fine_temperature;

  modport source (output valid, output humidity_q10, output fine_temperature, input ready);
  modport sink (input valid, input humidity_q10, input fine_temperature, output ready);
endinterface

// ----- sv/humsc_temp.sv -----
// humsc_temp: three-stage pipeline computing the fine temperature
// depends on humsc_pkg

module humsc_temp
  import humsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  humsc_cal_t  cal,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] adc_t,
  input  logic [15:0] adc_h,
  output logic        out_valid,
  input  logic        out_ready,
  output humsc_temp_t out_data
);

  logic [2:0] vld;
  logic [2:0] en;

  // stage 1
  logic [31:0] p_v1, p_dd;
  logic [15:0] adc_h1;
  // stage 2
  logic [31:0] v1s, p_m2;
  logic [15:0] adc_h2;
  // stage 3
  logic [31:0] tfine;
  logic [15:0] adc_h3;

  logic [31:0] t1_c, d_c, t2_32, t3_32;
  logic signed [31:0] v1s_c, dds_c, m2s_c;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign in_ready = en[0];

  always_comb begin
    t1_c  = {15'd0, adc_t[19:3]} - {15'd0, cal.temp_cal_1, 1'b0};
    d_c   = {16'd0, adc_t[19:4]} - {16'd0, cal.temp_cal_1};
    t2_32 = {{16{cal.temp_cal_2[15]}}, cal.temp_cal_2};
    t3_32 = {{16{cal.temp_cal_3[15]}}, cal.temp_cal_3};
    v1s_c = $signed(p_v1) >>> 11;
    dds_c = $signed(p_dd) >>> 12;
    m2s_c = $signed(p_m2) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_v1   <= t1_c * t2_32;
      p_dd   <= d_c * d_c;
      adc_h1 <= adc_h;
    end
    if (en[1]) begin
      v1s    <= v1s_c;
      p_m2   <= dds_c * $signed(t3_32);
      adc_h2 <= adc_h1;
    end
    if (en[2]) begin
      tfine  <= v1s + m2s_c;
      adc_h3 <= adc_h2;
    end
  end

  assign out_valid      = vld[2];
  assign out_data.tfine = tfine;
  assign out_data.adc_h = adc_h3;

endmodule

// ----- sv/humsc_hum.sv -----
// humsc_hum: seven-stage pipeline for humidity compensation and clamping
// depends on humsc_pkg; fed with the fine temperature from humsc_temp

module humsc_hum
  import humsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  humsc_cal_t   cal,
  input  logic         in_valid,
  output logic         in_ready,
  input  humsc_temp_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [16:0]  humidity_q10,
  output logic [31:0]  fine_temperature
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;
  logic [31:0]     tf [NSTG];

  logic [11:0] h4, h5;
  logic [31:0] x_c, h6_32, h2_32;

  // stage a
  logic [31:0] aa, h5x, bx, cx;
  // stage b
  logic [31:0] a_b, bc;
  // stage c
  logic [31:0] a_c, p;
  // stages d to f
  logic [31:0] ab_d, ab_e, ab_f, qq, r;
  // output stage
  logic [16:0] hum_o;

  logic [31:0] a_sum, c_c, b2_c, p_r, x2_c, hum_c;
  logic signed [31:0] a_s, b_s, c_s, bc_s, b3_s, q_s, qq_s, r_s;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    h4    = {cal.hum_cal_45_bytes[23:16], cal.hum_cal_45_bytes[11:8]};
    h5    = {cal.hum_cal_45_bytes[7:0], cal.hum_cal_45_bytes[15:12]};
    h6_32 = {{24{cal.hum_cal_6[7]}}, cal.hum_cal_6};
    h2_32 = {{16{cal.hum_cal_2[15]}}, cal.hum_cal_2};
    x_c   = in_data.tfine - TFINE_OFS;

    a_sum = aa - h5x + ROUND_A;
    a_s   = $signed(a_sum) >>> 15;
    b_s   = $signed(bx) >>> 10;
    c_s   = $signed(cx) >>> 11;
    c_c   = c_s + C_OFS;

    bc_s  = $signed(bc) >>> 10;
    b2_c  = bc_s + B_OFS;

    p_r   = p + ROUND_B;
    b3_s  = $signed(p_r) >>> 14;

    q_s   = $signed(ab_d) >>> 15;
    qq_s  = $signed(qq) >>> 7;
    r_s   = $signed(r) >>> 4;

    x2_c  = ab_f - r_s;
    // negative goes to zero, anything above full scale to full scale
    if (x2_c[31]) begin
      hum_c = '0;
    end else if (x2_c > HUM_MAX) begin
      hum_c = HUM_MAX;
    end else begin
      hum_c = x2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) tf[0] <= in_data.tfine;
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) tf[i] <= tf[i-1];
    end

    if (en[0]) begin
      aa  <= {2'd0, in_data.adc_h, 14'd0} - {h4, 20'd0};
      h5x <= {20'd0, h5} * x_c;
      bx  <= x_c * h6_32;
      cx  <= x_c * {24'd0, cal.hum_cal_3};
    end
    if (en[1]) begin
      a_b <= a_s;
      bc  <= b_s * $signed(c_c);
    end
    if (en[2]) begin
      a_c <= a_b;
      p   <= b2_c * h2_32;
    end
    if (en[3]) begin
      ab_d <= a_c * b3_s;
    end
    if (en[4]) begin
      ab_e <= ab_d;
      qq   <= q_s * q_s;
    end
    if (en[5]) begin
      ab_f <= ab_e;
      r    <= qq_s * $signed({24'd0, cal.hum_cal_1});
    end
    if (en[6]) begin
      hum_o <= hum_c[28:12];
    end
  end

  assign out_valid        = vld[NSTG-1];
  assign humidity_q10     = hum_o;
  assign fine_temperature = tf[NSTG-1];

endmodule

// ----- sv/humidity_sensor_compensation_core.sv -----
// humidity_sensor_compensation_core: top level with calibration registers
// depends on humsc_pkg, humsc_ifs, humsc_temp and humsc_hum

// Takes one sample transaction (raw temperature and raw humidity) per clock
// while the pipeline is not stalled and returns one result transaction per
// sample, in order, with humidity in 1/1024 %RH clamped to 0..102400 and the
// fine temperature. The block sustains one transaction per cycle while the
// result channel is ready. The chain has ten register stages (three for the
// temperature path, seven for humidity, the first loaded at acceptance), each
// at most one 32-bit multiply deep. Back-pressure on the result channel stalls
// stages only as far back as they are full, so empty slots still take new
// samples. The user must write calibration words through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. All of them reset to zero.

module humidity_sensor_compensation_core
  import humsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  humsc_sample_if.sink          sample,
  humsc_result_if.source        result
);

  humsc_cal_t  cal;
  logic        mid_valid;
  logic        mid_ready;
  humsc_temp_t mid_data;
  logic [31:0] fine_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_CAL_1:       cal.temp_cal_1       <= cfg_data[15:0];
        REG_TEMP_CAL_2:       cal.temp_cal_2       <= cfg_data[15:0];
        REG_TEMP_CAL_3:       cal.temp_cal_3       <= cfg_data[15:0];
        REG_HUM_CAL_1:        cal.hum_cal_1        <= cfg_data[7:0];
        REG_HUM_CAL_2:        cal.hum_cal_2        <= cfg_data[15:0];
        REG_HUM_CAL_3:        cal.hum_cal_3        <= cfg_data[7:0];
        REG_HUM_CAL_45_BYTES: cal.hum_cal_45_bytes <= cfg_data[23:0];
        REG_HUM_CAL_6:        cal.hum_cal_6        <= cfg_data[7:0];
        default:              cal                  <= cal;
      endcase
    end
  end

  humsc_temp u_temp (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .adc_t     (sample.raw_temperature),
    .adc_h     (sample.raw_humidity),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  humsc_hum u_hum (
    .clk              (clk),
    .rst              (rst),
    .cal              (cal),
    .in_valid         (mid_valid),
    .in_ready         (mid_ready),
    .in_data          (mid_data),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .humidity_q10     (result.humidity_q10),
    .fine_temperature (fine_t)
  );

  assign result.fine_temperature = $signed(fine_t);

  // result never exceeds full scale
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.humidity_q10 <= 17'd102400)
    else $error("humidity result above full scale");

  // with the output draining, the whole pipeline moves and takes a sample
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!result.valid || result.ready) |-> sample.ready)
    else $error("sample refused while pipeline drains");

  // a calibration write lands in the addressed register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == REG_HUM_CAL_45_BYTES) |=>
      cal.hum_cal_45_bytes == $past(cfg_data[23:0]))
    else $error("calibration write lost");

endmodule

// ----- bench/humidity_sensor_compensation_core_tb.sv -----
// humidity_sensor_compensation_core_tb: self-checking bench for the compensation core
// drives sample transactions, writes calibration between phases, checks every result
// depends on humsc_pkg, humsc_ifs and humidity_sensor_compensation_core

module humidity_sensor_compensation_core_tb;
  import humsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } reading_t;

  typedef struct packed {
    logic [16:0] humidity_q10;
    logic [31:0] fine_temperature;
  } comp_t;

  localparam int HOLD_CYCLES = 100;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  humsc_sample_if sample_ch();
  humsc_result_if result_ch();

  humidity_sensor_compensation_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  humsc_cal_t cal;
  reading_t   pending[$];
  comp_t      results_due[$];
  comp_t      want;
  reading_t   next_reading;
  bit         sample_sent;
  bit         no_idle;
  bit         hold_armed;
  int         send_gap;
  int         recv_gap;
  int         hold_count;
  int         mismatches;

  always #5 clk = ~clk;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return $signed(x) >>> n;
  endfunction

  // 32-bit integer compensation, every step wrapping at 32 bits
  function automatic comp_t compensate_sample(humsc_cal_t c, reading_t s);
    logic [31:0] adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, v2, d, tfine, x, a, b, cc, q, hum;
    comp_t       r;
    adc_t = {12'd0, s.raw_temperature};
    adc_h = {16'd0, s.raw_humidity};
    t1 = {16'd0, c.temp_cal_1};
    t2 = {{16{c.temp_cal_2[15]}}, c.temp_cal_2};
    t3 = {{16{c.temp_cal_3[15]}}, c.temp_cal_3};
    h1 = {24'd0, c.hum_cal_1};
    h2 = {{16{c.hum_cal_2[15]}}, c.hum_cal_2};
    h3 = {24'd0, c.hum_cal_3};
    // calibrations four and five share the middle byte
    h4 = {20'd0, c.hum_cal_45_bytes[23:16], c.hum_cal_45_bytes[11:8]};
    h5 = {20'd0, c.hum_cal_45_bytes[7:0], c.hum_cal_45_bytes[15:12]};
    h6 = {{24{c.hum_cal_6[7]}}, c.hum_cal_6};

    v1 = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    v2 = asr(asr(d * d, 12) * t3, 14);
    tfine = v1 + v2;

    x = tfine - TFINE_OFS;
    a = asr((adc_h << 14) - (h4 << 20) - (h5 * x) + ROUND_A, 15);
    b = asr(x * h6, 10);
    cc = asr(x * h3, 11) + C_OFS;
    b = asr(b * cc, 10) + B_OFS;
    b = asr(b * h2 + ROUND_B, 14);
    x = a * b;
    q = asr(x, 15);
    x = x - asr(asr(q * q, 7) * h1, 4);

    if (x[31]) hum = '0;
    else if (x > HUM_MAX) hum = HUM_MAX;
    else hum = x;

    r.humidity_q10 = hum[28:12];
    r.fine_temperature = tfine;
    return r;
  endfunction

  // sender: a new transaction is offered once the previous one has gone
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_sent) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_ch.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        next_reading = pending.pop_front();
        sample_ch.valid <= 1'b1;
        sample_ch.raw_temperature <= next_reading.raw_temperature;
        sample_ch.raw_humidity <= next_reading.raw_humidity;
        send_gap = no_idle ? 0 : draw_gap();
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off while armed
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count++;
      result_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      recv_gap = no_idle ? 0 : draw_gap();
    end
  end

  always @(posedge clk) begin
    sample_sent = 1'b0;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        sample_sent = 1'b1;
        results_due.push_back(compensate_sample(cal,
          {sample_ch.raw_temperature, sample_ch.raw_humidity}));
      end
      if (result_ch.valid && result_ch.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result transaction: humidity_q10 %0d fine_temperature %0d",
                   $time, result_ch.humidity_q10, $signed(result_ch.fine_temperature));
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (result_ch.humidity_q10 !== want.humidity_q10) begin
            $display("%0t: humidity_q10 expected %0d actual %0d",
                     $time, want.humidity_q10, result_ch.humidity_q10);
            mismatches++;
          end
          if (result_ch.fine_temperature !== want.fine_temperature) begin
            $display("%0t: fine_temperature expected %0d actual %0d", $time,
                     $signed(want.fine_temperature), $signed(result_ch.fine_temperature));
            mismatches++;
          end
        end
      end
    end
  end

  task automatic write_cal(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    // bits above each register's width are dropped
    case (idx)
      REG_TEMP_CAL_1:       cal.temp_cal_1 = data[15:0];
      REG_TEMP_CAL_2:       cal.temp_cal_2 = data[15:0];
      REG_TEMP_CAL_3:       cal.temp_cal_3 = data[15:0];
      REG_HUM_CAL_1:        cal.hum_cal_1 = data[7:0];
      REG_HUM_CAL_2:        cal.hum_cal_2 = data[15:0];
      REG_HUM_CAL_3:        cal.hum_cal_3 = data[7:0];
      REG_HUM_CAL_45_BYTES: cal.hum_cal_45_bytes = data[23:0];
      REG_HUM_CAL_6:        cal.hum_cal_6 = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cal(logic [CFG_DATA_W-1:0] t1, logic [CFG_DATA_W-1:0] t2,
                          logic [CFG_DATA_W-1:0] t3, logic [CFG_DATA_W-1:0] h1,
                          logic [CFG_DATA_W-1:0] h2, logic [CFG_DATA_W-1:0] h3,
                          logic [CFG_DATA_W-1:0] h45, logic [CFG_DATA_W-1:0] h6);
    write_cal(REG_TEMP_CAL_1, t1);
    write_cal(REG_TEMP_CAL_2, t2);
    write_cal(REG_TEMP_CAL_3, t3);
    write_cal(REG_HUM_CAL_1, h1);
    write_cal(REG_HUM_CAL_2, h2);
    write_cal(REG_HUM_CAL_3, h3);
    write_cal(REG_HUM_CAL_45_BYTES, h45);
    write_cal(REG_HUM_CAL_6, h6);
  endtask

  task automatic queue_reading(logic [19:0] t, logic [15:0] h);
    pending.push_back({t, h});
  endtask

  task automatic queue_random(int n);
    logic [19:0] t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) t = 20'($urandom());
      else t = 20'($urandom_range(380000, 620000));
      queue_reading(t, 16'($urandom()));
    end
  endtask

  // checked at the rising edge, where the sender's offer has settled
  task automatic wait_idle();
    while (pending.size() != 0 || sample_ch.valid || results_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("humidity_sensor_compensation_core_tb: FAIL");
    $finish;
  end

  initial begin
    logic [11:0] h4v, h5v;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.raw_temperature = '0;
    sample_ch.raw_humidity = '0;
    result_ch.ready = 1'b0;
    cal = '0;
    mismatches = 0;
    no_idle = 1'b0;
    hold_armed = 1'b0;
    hold_count = 0;
    send_gap = 0;
    recv_gap = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // calibration still at its reset value
    queue_reading(20'd0, 16'd0);
    queue_reading(20'hFFFFF, 16'hFFFF);
    queue_reading(20'd519888, 16'd30000);
    wait_idle();

    // a typical part: low and high humidity clamp, mid-range readings
    load_cal(24'd27504, 24'd26435, 24'h00FC18, 24'd75, 24'd362, 24'd0,
             24'h132903, 24'd30);
    queue_reading(20'd0, 16'd0);
    queue_reading(20'hFFFFF, 16'hFFFF);
    queue_reading(20'hFFFFF, 16'd0);
    queue_reading(20'd0, 16'hFFFF);
    queue_reading(20'd519888, 16'd30000);
    queue_reading(20'd519888, 16'd0);
    queue_reading(20'd519888, 16'hFFFF);
    queue_reading(20'd440000, 16'd20000);
    queue_reading(20'd600000, 16'd40000);
    queue_reading(20'd380000, 16'd25000);
    wait_idle();

    // largest calibration, junk above the register widths
    load_cal(24'hFFFFFF, 24'hFF7FFF, 24'hAA7FFF, 24'hFFFFFF, 24'h557FFF, 24'hFFFFFF,
             24'hFFFFFF, 24'hFFFF7F);
    queue_reading(20'd0, 16'd0);
    queue_reading(20'hFFFFF, 16'hFFFF);
    queue_reading(20'hFFFFF, 16'd0);
    queue_reading(20'd0, 16'hFFFF);
    wait_idle();

    // most negative signed words, zero unsigned ones
    load_cal(24'h000000, 24'h008000, 24'h008000, 24'h000000, 24'h008000, 24'h000000,
             24'h000000, 24'h000080);
    queue_reading(20'd0, 16'd0);
    queue_reading(20'hFFFFF, 16'hFFFF);
    queue_reading(20'hFFFFF, 16'd0);
    queue_reading(20'd0, 16'hFFFF);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) begin
        // plausible part-to-part spread
        h4v = 12'($urandom_range(280, 340));
        h5v = 12'($urandom_range(0, 60));
        load_cal(24'($urandom_range(26000, 29000)), 24'($urandom_range(25000, 28000)),
                 24'(32'hFFFF_FFFF - $urandom_range(0, 2000)), 24'($urandom_range(0, 255)),
                 24'($urandom_range(300, 420)), 24'($urandom_range(0, 10)),
                 {h4v[11:4], h5v[3:0], h4v[3:0], h5v[11:4]}, 24'($urandom_range(20, 40)));
      end else begin
        load_cal(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                 24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()));
      end
      no_idle = (ph == 1 || ph == 3);
      hold_armed = (ph == 3);
      if (ph == 5) begin
        // sender stops mid-phase until the pipeline has emptied
        queue_random(50);
        wait_idle();
        queue_random(50);
      end else begin
        queue_random(100);
      end
      wait_idle();
      hold_armed = 1'b0;
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("humidity_sensor_compensation_core_tb: PASS");
    end else begin
      $display("humidity_sensor_compensation_core_tb: FAIL");
    end
    $finish;
  end

endmodule
